@@ rtl/gf_erasure_parity_accumulator_assert.svh @@
// Assertion macros used by the checker file.
`ifndef GF_ERASURE_PARITY_ACCUMULATOR_ASSERT_SVH
`define GF_ERASURE_PARITY_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GFE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gfe_pkg.sv @@
package gfe_pkg;

    localparam logic [1:0] ACT_COEF  = 2'd0;
    localparam logic [1:0] ACT_ACCUM = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic CFG_FIELD_MODE   = 1'b0;
    localparam logic CFG_PARITY_COUNT = 1'b1;

    // reduction terms: GF(2^8) 0x11D (bit 8 cancels the shifted carry), GF(2^16) 0x1100B
    localparam logic [15:0] RED8  = 16'h011D;
    localparam logic [15:0] RED16 = 16'h100B;

    typedef struct packed {
        logic        start;
        logic        mode;
        logic [15:0] a;
        logic [15:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] prod;
    } mul_rsp_t;

    // one MSB-first shift-and-add step of a field multiply
    function automatic logic [15:0] gf_step(input logic [15:0] acc, input logic [15:0] a,
                                            input logic bit_in, input logic mode);
        logic        carry;
        logic [15:0] t;
        carry = mode ? acc[15] : acc[7];
        t = {acc[14:0], 1'b0};
        if (carry) begin
            t = t ^ (mode ? RED16 : RED8);
        end
        if (bit_in) begin
            t = t ^ a;
        end
        return t;
    endfunction

endpackage

@@ rtl/gfe_ram.sv @@
module gfe_ram #(
    parameter int AW = 7,
    parameter int DW = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gfe_gf_mult.sv @@
module gfe_gf_mult (
    input  logic              aclk,
    input  logic              aresetn,
    input  gfe_pkg::mul_req_t req,
    output gfe_pkg::mul_rsp_t rsp
);

    logic [15:0] acc_reg, acc_next;
    logic [15:0] a_reg;
    logic [15:0] b_reg;
    logic        mode_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    // four bits of b per cycle
    always_comb begin
        acc_next = acc_reg;
        for (int i = 0; i < 4; i++) begin
            acc_next = gfe_pkg::gf_step(acc_next, a_reg, b_reg[15-i], mode_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else if (req.start) begin
            acc_reg  <= 16'd0;
            a_reg    <= req.a;
            b_reg    <= req.b;
            mode_reg <= req.mode;
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[11:0], 4'd0};
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == 2'd3) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

@@ rtl/gf_erasure_parity_accumulator.sv @@
// Reed-Solomon erasure parity accumulator, GF(2^8) (0x11D) or GF(2^16) (0x1100B).
// Input stream s_*: one transaction per command; s_tuser carries the action
// (0 write coefficient, 1 accumulate data word, 2 read parity word).
// Output stream m_*: exactly one transaction per command; m_tdata is the parity
// word (zero unless a good read), m_tuser the status (1 = index error / bad action).
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 field_mode, 1 parity_count.
// For an accumulate each active store in turn costs one memory read, a multiply
// (4 bits of the word per cycle) and one write-back into the parity RAM.
// An accumulate to word 0 of packet 0 first sweeps the active stores to zero.
// One command is worked at a time; s_tready is high only while idle.
// After reset a clearing pass zeroes the parity RAM with s_tready low; config
// writes are still taken.
// A finished result sits in the output register; if m_tready is low the next
// command is still accepted, and its result waits until the register frees.
module gf_erasure_parity_accumulator #(
    parameter int MAX_PARITY = 8,
    parameter int MAX_DATA   = 16,
    parameter int BUF_WORDS  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] parity_index, [6:3] data_packet, [16:7] word_index,
    // [32:17] operand, [39:33] zero
    input  logic [39:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] parity_word
    output logic [15:0] m_tdata,
    // [0] status
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata
);

    localparam int PW  = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int DW  = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int BW  = $clog2(BUF_WORDS);
    localparam int NW  = $clog2(MAX_PARITY + 1);
    localparam logic [BW-1:0] W_LAST = BW'(BUF_WORDS - 1);
    localparam logic [NW-1:0] P_LAST = NW'(MAX_PARITY - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DEC, S_CLR, S_ARD, S_AMUL, S_AWAIT, S_RDW, S_DONE
    } state_t;

    state_t state_reg;

    logic          field_mode_reg;
    logic [3:0]    parity_count_reg;

    logic [1:0]    act_reg;
    logic [2:0]    pidx_reg;
    logic [3:0]    pkt_reg;
    logic [9:0]    widx_reg;
    logic [15:0]   opnd_reg;
    logic [NW-1:0] p_reg;
    logic [BW-1:0] w_reg;
    logic [15:0]   res_word_reg;
    logic          res_stat_reg;
    logic          out_valid_reg;
    logic [15:0]   out_word_reg;
    logic          out_stat_reg;

    logic [NW-1:0] active_n;
    logic          pidx_ok, pkt_ok, widx_ok;
    logic          out_load;

    // memory ports
    logic             coef_we, coef_re;
    logic [PW+DW-1:0] coef_waddr, coef_raddr;
    logic [15:0]      coef_rdata;
    logic             par_we, par_re;
    logic [PW+BW-1:0] par_waddr, par_raddr;
    logic [15:0]      par_wdata, par_rdata;

    gfe_pkg::mul_req_t mreq;
    gfe_pkg::mul_rsp_t mrsp;
    logic              beyond;

    always_comb begin
        if (5'(parity_count_reg) > 5'(MAX_PARITY)) begin
            active_n = NW'(MAX_PARITY);
        end else begin
            active_n = NW'(parity_count_reg);
        end
    end

    assign pidx_ok = 5'(pidx_reg) < 5'(active_n);
    assign pkt_ok  = 7'(pkt_reg) < 7'(MAX_DATA);
    assign widx_ok = 13'(widx_reg) < 13'(BUF_WORDS);

    // result register loads once it is free or being drained
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // coefficient RAM: written by a coefficient command, read per store
    assign coef_we    = (state_reg == S_DEC) && (act_reg == gfe_pkg::ACT_COEF)
                        && pidx_ok && pkt_ok;
    assign coef_waddr = {PW'(pidx_reg), DW'(pkt_reg)};
    assign coef_re    = (state_reg == S_ARD);
    assign coef_raddr = {PW'(p_reg), DW'(pkt_reg)};

    // parity RAM: zeroing sweeps and accumulate write-back share the write port
    always_comb begin
        par_we    = 1'b0;
        par_waddr = {PW'(p_reg), w_reg};
        par_wdata = 16'd0;
        if ((state_reg == S_INIT) || (state_reg == S_CLR)) begin
            par_we = 1'b1;
        end else if ((state_reg == S_AWAIT) && mrsp.done) begin
            par_we    = 1'b1;
            par_waddr = {PW'(p_reg), BW'(widx_reg)};
            par_wdata = par_rdata ^ mrsp.prod;
        end
    end

    always_comb begin
        par_re    = 1'b0;
        par_raddr = {PW'(p_reg), BW'(widx_reg)};
        if (state_reg == S_ARD) begin
            par_re = 1'b1;
        end else if ((state_reg == S_DEC) && (act_reg == gfe_pkg::ACT_READ)) begin
            par_re    = 1'b1;
            par_raddr = {PW'(pidx_reg), BW'(widx_reg)};
        end
    end

    // byte mode: an operand above 255 lies outside the field, product zero
    assign beyond     = !field_mode_reg && ((coef_rdata[15:8] != 8'd0)
                        || (opnd_reg[15:8] != 8'd0));
    assign mreq.start = (state_reg == S_AMUL);
    assign mreq.mode  = field_mode_reg;
    assign mreq.a     = beyond ? 16'd0 : coef_rdata;
    assign mreq.b     = opnd_reg;

    gfe_ram #(.AW(PW + DW), .DW(16)) u_coef (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (opnd_reg),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    gfe_ram #(.AW(PW + BW), .DW(16)) u_parity (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    gfe_gf_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_mode_reg   <= 1'b0;
            parity_count_reg <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gfe_pkg::CFG_FIELD_MODE:   field_mode_reg   <= cfg_wdata[0];
                gfe_pkg::CFG_PARITY_COUNT: parity_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            p_reg         <= '0;
            w_reg         <= '0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: begin
                    if (w_reg == W_LAST) begin
                        w_reg <= '0;
                        if (p_reg == P_LAST) begin
                            p_reg     <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            p_reg <= p_reg + 1'b1;
                        end
                    end else begin
                        w_reg <= w_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        act_reg   <= s_tuser;
                        pidx_reg  <= s_tdata[2:0];
                        pkt_reg   <= s_tdata[6:3];
                        widx_reg  <= s_tdata[16:7];
                        opnd_reg  <= s_tdata[32:17];
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    res_word_reg <= 16'd0;
                    p_reg        <= '0;
                    w_reg        <= '0;
                    priority if (act_reg == gfe_pkg::ACT_COEF) begin
                        res_stat_reg <= !(pidx_ok && pkt_ok);
                        state_reg    <= S_DONE;
                    end else if (act_reg == gfe_pkg::ACT_READ) begin
                        // a good read clears the status in S_RDW
                        res_stat_reg <= 1'b1;
                        if (pidx_ok && widx_ok) begin
                            state_reg <= S_RDW;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else if (act_reg == gfe_pkg::ACT_ACCUM) begin
                        res_stat_reg <= !(pkt_ok && widx_ok);
                        if (!(pkt_ok && widx_ok) || (active_n == '0)) begin
                            state_reg <= S_DONE;
                        end else if ((pkt_reg == 4'd0) && (widx_reg == 10'd0)) begin
                            state_reg <= S_CLR;
                        end else begin
                            state_reg <= S_ARD;
                        end
                    end else begin
                        res_stat_reg <= 1'b1;
                        state_reg    <= S_DONE;
                    end
                end
                S_CLR: begin
                    if (w_reg == W_LAST) begin
                        w_reg <= '0;
                        if (p_reg == active_n - 1'b1) begin
                            p_reg     <= '0;
                            state_reg <= S_ARD;
                        end else begin
                            p_reg <= p_reg + 1'b1;
                        end
                    end else begin
                        w_reg <= w_reg + 1'b1;
                    end
                end
                S_ARD: begin
                    state_reg <= S_AMUL;
                end
                S_AMUL: begin
                    state_reg <= S_AWAIT;
                end
                S_AWAIT: begin
                    if (mrsp.done) begin
                        if (p_reg == active_n - 1'b1) begin
                            state_reg <= S_DONE;
                        end else begin
                            p_reg     <= p_reg + 1'b1;
                            state_reg <= S_ARD;
                        end
                    end
                end
                S_RDW: begin
                    res_word_reg <= par_rdata;
                    res_stat_reg <= 1'b0;
                    state_reg    <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        out_word_reg  <= res_word_reg;
                        out_stat_reg  <= res_stat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_stat_reg;

endmodule

@@ rtl/gfe_checker.sv @@
`include "gf_erasure_parity_accumulator_assert.svh"

module gfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    `GFE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `GFE_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `GFE_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 16'd0, "error result with nonzero word")
    `GFE_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second command taken while busy")

endmodule

bind gf_erasure_parity_accumulator gfe_checker u_gfe_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    // action code the block must reject
    localparam logic [1:0]  ACT_BAD    = 2'd3;
    // field reduction polynomials, full width
    localparam logic [16:0] POLY_GF8   = 17'h0011D;
    localparam logic [16:0] POLY_GF16  = 17'h1100B;
    localparam int          NUM_STORES = 8;
    localparam int          NUM_PKTS   = 16;
    localparam int          NUM_WORDS  = 1024;

    typedef struct {
        logic [1:0]  action;
        logic [2:0]  pidx;
        logic [3:0]  pkt;
        logic [9:0]  widx;
        logic [15:0] operand;
    } command_t;

    typedef struct {
        logic [15:0] word;
        logic        status;
    } reply_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [3:0]  cfg_wdata = '0;

    // our own copy of the block's state
    logic        wide_field;
    logic [3:0]  store_count;
    logic [15:0] coef_mem [NUM_STORES][NUM_PKTS];
    logic [15:0] parity_mem [NUM_STORES][NUM_WORDS];

    command_t pending_cmds[$];
    reply_t   expected_replies[$];
    command_t cur_cmd;
    int       mismatches = 0;
    int       cycle_no = 0;
    logic     gen_wide;

    gf_erasure_parity_accumulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) cycle_no <= cycle_no + 1;

    // idling off for one long window, otherwise a gap on about 16 in 100 calls
    function automatic logic take_gap();
        if (cycle_no > 20000 && cycle_no < 26000) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 16;
    endfunction

    // shift-and-add field multiply; out-of-field operands give zero
    function automatic logic [15:0] field_mul(logic [15:0] a, logic [15:0] b, logic wide);
        logic [16:0] acc;
        acc = '0;
        if (a == 0 || b == 0 || (!wide && (a > 16'd255 || b > 16'd255))) begin
            return 16'h0;
        end
        for (int i = 15; i >= 0; i--) begin
            acc = acc << 1;
            if (wide && acc[16]) begin
                acc = acc ^ POLY_GF16;
            end else if (!wide && acc[8]) begin
                acc = acc ^ POLY_GF8;
            end
            if (b[i]) begin
                acc = acc ^ {1'b0, a};
            end
        end
        return acc[15:0];
    endfunction

    // work out the reply for one accepted transaction and update the state copy
    function automatic reply_t apply_command(command_t c);
        reply_t r;
        int     n;
        n = (store_count > NUM_STORES) ? NUM_STORES : store_count;
        r.word = '0;
        r.status = 1'b1;
        case (c.action)
            gfe_pkg::ACT_COEF: begin
                if (c.pidx < n) begin
                    coef_mem[c.pidx][c.pkt] = c.operand;
                    r.status = 1'b0;
                end
            end
            gfe_pkg::ACT_ACCUM: begin
                // start of a group: wipe the active stores first
                if (c.pkt == 0 && c.widx == 0) begin
                    for (int p = 0; p < n; p++) begin
                        for (int w = 0; w < NUM_WORDS; w++) parity_mem[p][w] = '0;
                    end
                end
                for (int p = 0; p < n; p++) begin
                    parity_mem[p][c.widx] ^= field_mul(coef_mem[p][c.pkt], c.operand,
                                                       wide_field);
                end
                r.status = 1'b0;
            end
            gfe_pkg::ACT_READ: begin
                if (c.pidx < n) begin
                    r.word = parity_mem[c.pidx][c.widx];
                    r.status = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: offers pending commands, predicts on each accepted transaction
    always @(posedge aclk) begin
        logic     load;
        command_t nxt;
        load = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(apply_command(cur_cmd));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() > 0 && !take_gap()) begin
                    nxt = pending_cmds.pop_front();
                    cur_cmd <= nxt;
                    s_tdata <= {7'b0, nxt.operand, nxt.widx, nxt.pkt, nxt.pidx};
                    s_tuser <= nxt.action;
                    load = 1'b1;
                end
                s_tvalid <= load;
            end
        end
    end

    // receiver back-pressure, with long hold-offs to fill the block up
    int hold_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (cycle_no == 17200 || cycle_no == 60000) begin
            hold_left <= 1500;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !take_gap();
        end
    end

    // monitor: each result transaction against the oldest expectation
    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word=%h status=%b", m_tdata, m_tuser);
            end else begin
                exp_r = expected_replies.pop_front();
                if (m_tdata !== exp_r.word || m_tuser !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: word exp %h got %h, status exp %b got %b",
                                 exp_r.word, m_tdata, exp_r.status, m_tuser);
                end
            end
        end
    end

    task automatic write_reg(logic idx, logic [3:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == gfe_pkg::CFG_FIELD_MODE) wide_field = val[0];
        else store_count = val;
    endtask

    task automatic set_mode(logic wide, logic [3:0] count);
        write_reg(gfe_pkg::CFG_FIELD_MODE, {3'b0, wide});
        write_reg(gfe_pkg::CFG_PARITY_COUNT, count);
        gen_wide = wide;
    endtask

    task automatic queue_cmd(logic [1:0] act, logic [2:0] pi, logic [3:0] pk,
                             logic [9:0] wi, logic [15:0] op);
        command_t c;
        c.action = act; c.pidx = pi; c.pkt = pk; c.widx = wi; c.operand = op;
        pending_cmds.push_back(c);
    endtask

    // sender holds back until every expected result is in
    task automatic wait_all_done();
        do @(posedge aclk);
        while (pending_cmds.size() > 0 || s_tvalid || expected_replies.size() > 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_traffic(int count);
        int         kind;
        logic [15:0] op;
        logic [9:0]  wi;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            op = (gen_wide || $urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 255));
            wi = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
            if (kind < 3) begin
                // new group: packet 0 word 0 clears the stores
                queue_cmd(gfe_pkg::ACT_ACCUM, 3'($urandom), 4'd0, 10'd0, op);
            end else if (kind < 52) begin
                queue_cmd(gfe_pkg::ACT_ACCUM, 3'($urandom), 4'($urandom), wi, op);
            end else if (kind < 84) begin
                queue_cmd(gfe_pkg::ACT_READ, 3'($urandom), 4'($urandom), wi, op);
            end else if (kind < 96) begin
                queue_cmd(gfe_pkg::ACT_COEF, 3'($urandom), 4'($urandom), wi, op);
            end else begin
                queue_cmd(ACT_BAD, 3'($urandom), 4'($urandom), wi, op);
            end
        end
    endtask

    initial begin
        wide_field  = 1'b0;
        store_count = 4'd1;
        gen_wide    = 1'b0;
        for (int p = 0; p < NUM_STORES; p++)
            for (int w = 0; w < NUM_WORDS; w++) parity_mem[p][w] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // every coefficient gets written once so no accumulate reads an unset one
        set_mode(1'b1, 4'd8);
        for (int p = 0; p < NUM_STORES; p++) begin
            for (int k = 0; k < NUM_PKTS; k++) begin
                queue_cmd(gfe_pkg::ACT_COEF, 3'(p), 4'(k), 10'($urandom),
                          (p == 0 && k == 1) ? 16'h0000 :
                          (p == 7 && k == 15) ? 16'hFFFF : 16'($urandom));
            end
        end
        // directed: group start, extreme words and operands, accumulate, read and a bad action
        queue_cmd(gfe_pkg::ACT_ACCUM, 3'd0, 4'd0, 10'd0, 16'hFFFF);
        queue_cmd(gfe_pkg::ACT_ACCUM, 3'd7, 4'd15, 10'd1023, 16'hFFFF);
        queue_cmd(gfe_pkg::ACT_ACCUM, 3'd0, 4'd1, 10'd1023, 16'h1234);
        queue_cmd(gfe_pkg::ACT_ACCUM, 3'd0, 4'd2, 10'd5, 16'h0000);
        queue_cmd(gfe_pkg::ACT_READ, 3'd7, 4'd0, 10'd1023, 16'h0);
        queue_cmd(gfe_pkg::ACT_READ, 3'd0, 4'd15, 10'd0, 16'hFFFF);
        queue_cmd(gfe_pkg::ACT_READ, 3'd3, 4'd0, 10'd5, 16'h0);
        queue_cmd(ACT_BAD, 3'd7, 4'd15, 10'd1023, 16'hFFFF);
        random_traffic(170);
        wait_all_done();

        // byte field: operands above 255 give zero products
        set_mode(1'b0, 4'd8);
        queue_cmd(gfe_pkg::ACT_COEF, 3'd2, 4'd3, 10'd0, 16'h00FF);
        queue_cmd(gfe_pkg::ACT_ACCUM, 3'd0, 4'd0, 10'd0, 16'h00FF);
        queue_cmd(gfe_pkg::ACT_ACCUM, 3'd0, 4'd3, 10'd7, 16'h0100);
        queue_cmd(gfe_pkg::ACT_ACCUM, 3'd0, 4'd3, 10'd7, 16'h0080);
        queue_cmd(gfe_pkg::ACT_READ, 3'd2, 4'd0, 10'd7, 16'h0);
        random_traffic(150);
        wait_all_done();

        // three stores: index errors above the active count
        set_mode(1'b1, 4'd3);
        queue_cmd(gfe_pkg::ACT_COEF, 3'd3, 4'd0, 10'd0, 16'h0001);
        queue_cmd(gfe_pkg::ACT_READ, 3'd5, 4'd0, 10'd0, 16'h0);
        queue_cmd(gfe_pkg::ACT_READ, 3'd2, 4'd0, 10'd0, 16'h0);
        random_traffic(150);
        wait_all_done();

        // no active stores: accumulate accepted, all else rejected
        set_mode(1'b0, 4'd0);
        queue_cmd(gfe_pkg::ACT_ACCUM, 3'd0, 4'd0, 10'd0, 16'h0055);
        queue_cmd(gfe_pkg::ACT_READ, 3'd0, 4'd0, 10'd0, 16'h0);
        queue_cmd(gfe_pkg::ACT_COEF, 3'd0, 4'd0, 10'd0, 16'h0001);
        random_traffic(120);
        wait_all_done();

        // count above the store limit saturates
        set_mode(1'b1, 4'd15);
        random_traffic(170);
        wait_all_done();

        set_mode(1'b0, 4'd1);
        random_traffic(140);
        wait_all_done();

        set_mode(1'b0, 4'd5);
        random_traffic(140);
        wait_all_done();

        set_mode(1'b1, 4'd8);
        random_traffic(80);
        wait_all_done();

        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
